>>> rtl/safety_message_frame_decoder_defines.svh
// Assertion macros for the safety message frame decoder.
`ifndef SAFETY_MESSAGE_FRAME_DECODER_DEFINES_SVH
`define SAFETY_MESSAGE_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SMFD_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SMFD_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error(msg);
`else
`define SMFD_ASSERT_IMPL(name, clk, rst_n, pre, post, msg)
`define SMFD_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/smfd_pkg.sv
// Types, constants and helper functions of the safety message frame decoder.
`default_nettype none
package smfd_pkg;

	localparam int unsigned MAX_FRAME_DEFAULT = 32;
	localparam int unsigned HDR_LEN = 9;
	localparam int unsigned STORE_LEN = 18;
	localparam int unsigned STORE_IDX_W = $clog2(STORE_LEN);
	localparam int unsigned COUNT_W = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Result status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ST_BAD_VALUE = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_TYPE = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_MASK = 2'd2;

	localparam logic [7:0] RST_EXPECTED_VERSION = 8'd1;
	localparam logic [7:0] RST_NODE_COUNT = 8'd8;
	localparam logic [7:0] RST_STATUS_MASK = 8'd255;

	// Message type codes
	localparam logic [7:0] MT_PLAIN_10 = 8'h10;
	localparam logic [7:0] MT_PLAIN_11 = 8'h11;
	localparam logic [7:0] MT_PLAIN_12 = 8'h12;
	localparam logic [7:0] MT_PLAIN_13 = 8'h13;
	localparam logic [7:0] MT_PLAIN_20 = 8'h20;
	localparam logic [7:0] MT_PLAIN_21 = 8'h21;
	localparam logic [7:0] MT_PLAIN_22 = 8'h22;
	localparam logic [7:0] MT_INCIDENT_30 = 8'h30;
	localparam logic [7:0] MT_INCIDENT_31 = 8'h31;
	localparam logic [7:0] MT_SPEED = 8'h40;
	localparam logic [7:0] MT_ENV = 8'h41;
	localparam logic [7:0] MT_INCIDENT_42 = 8'h42;
	localparam logic [7:0] MT_INCIDENT_43 = 8'h43;
	localparam logic [7:0] MT_HEARTBEAT = 8'h50;
	localparam logic [7:0] MT_ACK = 8'h51;

	// Sensor quality codes
	localparam logic [2:0] Q_VALID = 3'd0;
	localparam logic [2:0] Q_BELOW = 3'd1;
	localparam logic [2:0] Q_ABOVE = 3'd2;
	localparam logic [2:0] Q_SENSOR_ERR = 3'd3;
	localparam logic [2:0] Q_UNMEASURED = 3'd4;

	localparam logic [7:0] TEMP_TOP = 8'd250;
	localparam logic [7:0] HUM_TOP = 8'd200;
	localparam logic [15:0] TEMP_OFFSET = 16'd225;
	localparam logic [7:0] CODE_BELOW = 8'd251;
	localparam logic [7:0] CODE_ABOVE = 8'd252;
	localparam logic [7:0] CODE_SENSOR_ERR = 8'd253;
	localparam logic [7:0] CODE_UNMEASURED = 8'd254;
	localparam logic [7:0] ACK_OUTCOME_MAX = 8'd3;
	localparam logic [7:0] ACK_OUTCOME_TYPED = 8'd2;

	typedef logic [STORE_LEN-1:0][7:0] smfd_store_t;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [7:0] node_count;
		logic [7:0] status_mask;
	} smfd_cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] msg_type;
		logic [7:0] source_node;
		logic [31:0] session_number;
		logic [15:0] sequence_number;
		logic [31:0] ref_session;
		logic [15:0] ref_number;
		logic [7:0] acked_type;
		logic [1:0] ack_outcome;
		logic [15:0] value_a;
		logic [9:0] humidity_tenths;
		logic [6:0] flags;
	} smfd_result_t;

	typedef struct packed {
		logic known;
		logic [3:0] payload;
	} smfd_type_info_t;

	typedef struct packed {
		logic ok;
		logic [2:0] code;
	} smfd_quality_t;

	function automatic smfd_type_info_t type_info(input logic [7:0] t);
		smfd_type_info_t ti;
		ti = '{known: 1'b1, payload: 4'd0};
		case (t)
			MT_PLAIN_10, MT_PLAIN_11, MT_PLAIN_12, MT_PLAIN_13,
			MT_PLAIN_20, MT_PLAIN_21, MT_PLAIN_22: ti.payload = 4'd0;
			MT_INCIDENT_30, MT_INCIDENT_31,
			MT_INCIDENT_42, MT_INCIDENT_43: ti.payload = 4'd6;
			MT_SPEED: ti.payload = 4'd3;
			MT_ENV: ti.payload = 4'd2;
			MT_HEARTBEAT: ti.payload = 4'd1;
			MT_ACK: ti.payload = 4'd9;
			default: ti.known = 1'b0;
		endcase
		return ti;
	endfunction

	function automatic smfd_quality_t quality(input logic [7:0] b, input logic [7:0] top);
		smfd_quality_t q;
		q = '{ok: 1'b1, code: Q_VALID};
		if (b > top) begin
			case (b)
				CODE_BELOW: q.code = Q_BELOW;
				CODE_ABOVE: q.code = Q_ABOVE;
				CODE_SENSOR_ERR: q.code = Q_SENSOR_ERR;
				CODE_UNMEASURED: q.code = Q_UNMEASURED;
				default: q.ok = 1'b0;
			endcase
		end
		return q;
	endfunction

endpackage
`default_nettype wire

>>> rtl/smfd_byte_if.sv
// Byte channel into the decoder: one frame byte and its last flag per item.
`default_nettype none
interface smfd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/smfd_result_if.sv
// Result channel out of the decoder: one decoded frame per item.
`default_nettype none
interface smfd_result_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] msg_type;
	logic [7:0] source_node;
	logic [31:0] session_number;
	logic [15:0] sequence_number;
	logic [31:0] ref_session;
	logic [15:0] ref_number;
	logic [7:0] acked_type;
	logic [1:0] ack_outcome;
	logic [15:0] value_a;
	logic [9:0] humidity_tenths;
	logic [6:0] flags;

	modport source(output valid, input ready, output status, output msg_type,
		output source_node, output session_number, output sequence_number,
		output ref_session, output ref_number, output acked_type, output ack_outcome,
		output value_a, output humidity_tenths, output flags);
	modport sink(input valid, output ready, input status, input msg_type,
		input source_node, input session_number, input sequence_number,
		input ref_session, input ref_number, input acked_type, input ack_outcome,
		input value_a, input humidity_tenths, input flags);
endinterface
`default_nettype wire

>>> rtl/smfd_judge.sv
// Frame checker: validates a stored frame and decodes its payload fields.
`default_nettype none
module smfd_judge #(
	parameter int unsigned MAX_FRAME = smfd_pkg::MAX_FRAME_DEFAULT
) (
	input wire smfd_pkg::smfd_store_t store,
	input wire logic [smfd_pkg::COUNT_W-1:0] n,
	input wire smfd_pkg::smfd_cfg_t cfg,
	output smfd_pkg::smfd_result_t res
);
	localparam int unsigned P = smfd_pkg::HDR_LEN;

	smfd_pkg::smfd_result_t dec;
	smfd_pkg::smfd_type_info_t ti;
	smfd_pkg::smfd_type_info_t ack_ti;
	smfd_pkg::smfd_quality_t tq;
	smfd_pkg::smfd_quality_t hq;
	logic [7:0] t;
	logic [7:0] src;
	logic [7:0] a0;
	logic [7:0] k;
	logic [31:0] session;
	logic src_ok;
	logic a0_node_ok;
	logic pay_err;
	logic [2:0] st;

	assign t = store[1];
	assign src = store[2];
	assign a0 = store[P];
	assign k = store[P+8];
	assign session = {store[6], store[5], store[4], store[3]};
	assign src_ok = (src != 8'd0) && (src <= cfg.node_count);
	assign a0_node_ok = (a0 != 8'd0) && (a0 <= cfg.node_count);
	assign ti = smfd_pkg::type_info(t);
	assign ack_ti = smfd_pkg::type_info(store[P+7]);
	assign tq = smfd_pkg::quality(a0, smfd_pkg::TEMP_TOP);
	assign hq = smfd_pkg::quality(store[P+1], smfd_pkg::HUM_TOP);

	// Per-type payload decode and value checks
	always_comb begin
		dec = '0;
		pay_err = 1'b0;
		dec.msg_type = t;
		dec.source_node = src;
		dec.session_number = session;
		dec.sequence_number = {store[8], store[7]};
		case (t)
			smfd_pkg::MT_INCIDENT_30, smfd_pkg::MT_INCIDENT_31,
			smfd_pkg::MT_INCIDENT_42, smfd_pkg::MT_INCIDENT_43: begin
				dec.ref_session = {store[P+3], store[P+2], store[P+1], store[P]};
				dec.ref_number = {store[P+5], store[P+4]};
				pay_err = (dec.ref_session == 32'd0) || (dec.ref_number == 16'd0);
			end
			smfd_pkg::MT_SPEED: begin
				dec.value_a = {store[P+2], store[P+1]};
				dec.flags = 7'(a0);
				pay_err = (a0 > 8'd1) || ((a0 == 8'd0) && (dec.value_a != 16'd0));
			end
			smfd_pkg::MT_ENV: begin
				if (tq.code == smfd_pkg::Q_VALID) begin
					dec.value_a = 16'(a0) + smfd_pkg::TEMP_OFFSET;
				end
				if (hq.code == smfd_pkg::Q_VALID) begin
					// times five as shift and add
					dec.humidity_tenths = {store[P+1], 2'b00} + 10'(store[P+1]);
				end
				dec.flags = {hq.code, tq.code, 1'b0};
				pay_err = !tq.ok || !hq.ok;
			end
			smfd_pkg::MT_HEARTBEAT: begin
				dec.value_a = 16'(a0);
				pay_err = (a0 & ~cfg.status_mask) != 8'd0;
			end
			smfd_pkg::MT_ACK: begin
				dec.value_a = 16'(a0);
				dec.ref_session = {store[P+4], store[P+3], store[P+2], store[P+1]};
				dec.ref_number = {store[P+6], store[P+5]};
				dec.acked_type = store[P+7];
				dec.ack_outcome = k[1:0];
				pay_err = !a0_node_ok || (a0 == src) || (dec.ref_session == 32'd0)
					|| (store[P+7] == smfd_pkg::MT_ACK) || (k > smfd_pkg::ACK_OUTCOME_MAX)
					|| ((k < smfd_pkg::ACK_OUTCOME_TYPED) && !ack_ti.known);
			end
			default: pay_err = 1'b0;
		endcase
	end

	// Checks in priority order; the first failure wins
	always_comb begin
		if (n > smfd_pkg::COUNT_W'(MAX_FRAME)) begin
			st = smfd_pkg::ST_TOO_LARGE;
		end else if (store[0] != cfg.expected_version) begin
			st = smfd_pkg::ST_BAD_VERSION;
		end else if (n < smfd_pkg::COUNT_W'(P)) begin
			st = smfd_pkg::ST_BAD_LENGTH;
		end else if (!src_ok || (session == 32'd0)) begin
			st = smfd_pkg::ST_BAD_VALUE;
		end else if (!ti.known) begin
			st = smfd_pkg::ST_UNKNOWN_TYPE;
		end else if (n != smfd_pkg::COUNT_W'(P) + smfd_pkg::COUNT_W'(ti.payload)) begin
			st = smfd_pkg::ST_BAD_LENGTH;
		end else if (pay_err) begin
			st = smfd_pkg::ST_BAD_VALUE;
		end else begin
			st = smfd_pkg::ST_OK;
		end
	end

	always_comb begin
		if (st == smfd_pkg::ST_OK) begin
			res = dec;
		end else begin
			res = '0;
			res.status = st;
		end
	end
endmodule
`default_nettype wire

>>> rtl/safety_message_frame_decoder.sv
// Top level of the safety message frame decoder.
//
//  channel   direction  payload                                   handshake
//  frame     sink       data_byte[7:0], last_byte                 valid/ready
//  result    source     status .. flags (12 fields, 158 bits)     valid/ready
//  wr_*      sink       wr_index[1:0], wr_data[7:0]               wr_en only
//
// One byte item per cycle while frame.ready is high. A frame's result passes
// from its last accepted byte into the check stage, then through the checker
// logic into the result register.
// arst_n clears the byte count, the stage and result valid flags and loads
// the register reset values; the byte store is not cleared.
// frame.ready drops only while a checked frame waits in the check stage
// behind a result that the sink has not taken.
`default_nettype none
`include "safety_message_frame_decoder_defines.svh"
module safety_message_frame_decoder #(
	parameter int unsigned MAX_FRAME = smfd_pkg::MAX_FRAME_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	smfd_byte_if.sink frame,
	smfd_result_if.source result,
	input wire logic wr_en,
	input wire logic [smfd_pkg::CFG_IDX_W-1:0] wr_index,
	input wire logic [7:0] wr_data
);
	smfd_pkg::smfd_cfg_t cfg_q;
	smfd_pkg::smfd_store_t store_q;
	smfd_pkg::smfd_result_t judged;
	smfd_pkg::smfd_result_t res_q;
	logic [smfd_pkg::COUNT_W-1:0] count_q;
	logic [smfd_pkg::COUNT_W-1:0] count_inc;
	logic [smfd_pkg::COUNT_W-1:0] n_s1;
	logic v_s1;
	logic res_valid_q;
	logic adv;
	logic accept;

	assign adv = !res_valid_q || result.ready;
	assign frame.ready = !v_s1 || adv;
	assign accept = frame.valid && frame.ready;
	assign count_inc = (count_q == smfd_pkg::COUNT_MAX) ? count_q
		: count_q + smfd_pkg::COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= smfd_pkg::RST_EXPECTED_VERSION;
			cfg_q.node_count <= smfd_pkg::RST_NODE_COUNT;
			cfg_q.status_mask <= smfd_pkg::RST_STATUS_MASK;
		end else if (wr_en) begin
			case (wr_index)
				smfd_pkg::REG_EXPECTED_VERSION: cfg_q.expected_version <= wr_data;
				smfd_pkg::REG_NODE_COUNT: cfg_q.node_count <= wr_data;
				smfd_pkg::REG_STATUS_MASK: cfg_q.status_mask <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Keep the first bytes of the frame; later bytes are only counted
	always_ff @(posedge clk) begin
		if (accept && (count_q < smfd_pkg::COUNT_W'(smfd_pkg::STORE_LEN))) begin
			store_q[count_q[smfd_pkg::STORE_IDX_W-1:0]] <= frame.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= frame.last_byte ? '0 : count_inc;
			end
			if (frame.ready) begin
				v_s1 <= accept && frame.last_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame.last_byte) begin
			n_s1 <= count_inc;
		end
	end

	smfd_judge #(
		.MAX_FRAME(MAX_FRAME)
	) u_judge (
		.store(store_q),
		.n(n_s1),
		.cfg(cfg_q),
		.res(judged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_q <= judged;
		end
	end

	assign result.valid = res_valid_q;
	assign result.status = res_q.status;
	assign result.msg_type = res_q.msg_type;
	assign result.source_node = res_q.source_node;
	assign result.session_number = res_q.session_number;
	assign result.sequence_number = res_q.sequence_number;
	assign result.ref_session = res_q.ref_session;
	assign result.ref_number = res_q.ref_number;
	assign result.acked_type = res_q.acked_type;
	assign result.ack_outcome = res_q.ack_outcome;
	assign result.value_a = res_q.value_a;
	assign result.humidity_tenths = res_q.humidity_tenths;
	assign result.flags = res_q.flags;

	`SMFD_ASSERT_IMPL(a_err_fields_zero, clk, arst_n, result.valid && (result.status != smfd_pkg::ST_OK), (result.msg_type == 8'd0) && (result.session_number == 32'd0) && (result.value_a == 16'd0) && (result.flags == 7'd0), "error result carries nonzero fields")
	`SMFD_ASSERT_IMPL(a_status_range, clk, arst_n, result.valid, result.status <= smfd_pkg::ST_UNKNOWN_TYPE, "status code out of range")
	`SMFD_ASSERT_NEXT(a_count_clear, clk, arst_n, accept && frame.last_byte, (count_q == '0) && v_s1, "last byte did not close the frame")
	`SMFD_ASSERT_NEXT(a_count_step, clk, arst_n, accept && !frame.last_byte && (count_q != smfd_pkg::COUNT_MAX), count_q == $past(count_q) + smfd_pkg::COUNT_W'(1), "byte count did not advance")
	`SMFD_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, v_s1 && !adv, !frame.ready, "input taken while check stage is held")
endmodule
`default_nettype wire
